// ===== rtl/cau_pkg.sv =====
// cau_pkg: constants, widths and control structs of the class argmax and
// uncertainty block. Depends on nothing; used by every module in rtl.
`timescale 1ns / 1ps
package cau_pkg;

	localparam int MAX_CLASSES = 256;
	localparam int COUNT_BITS  = 16;

	localparam int CLASS_BITS = $clog2(MAX_CLASSES);
	localparam int CFG_BITS   = CLASS_BITS + 1;
	localparam int SUM_BITS   = COUNT_BITS + CLASS_BITS;
	localparam int PERCENT    = 100;
	localparam int QUO_BITS   = 7;
	localparam int DIV_BITS   = SUM_BITS + QUO_BITS;
	localparam int STEP_BITS  = $clog2(QUO_BITS);

	localparam int IN_DATA_BITS  = ((COUNT_BITS + 7) / 8) * 8;
	localparam int OUT_DATA_BITS = ((CLASS_BITS + QUO_BITS + 7) / 8) * 8;

	typedef struct packed {
		logic accept;
		logic div_load;
		logic div_step;
		logic out_load;
	} cau_cmd_t;

	typedef struct packed {
		logic last_item;
	} cau_status_t;

endpackage

// ===== rtl/cau_ctrl.sv =====
// cau_ctrl: controller state machine; sequences accumulate, divide and
// output load. Depends on cau_pkg.
`timescale 1ns / 1ps
module cau_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	input  cau_pkg::cau_status_t status,
	output cau_pkg::cau_cmd_t    cmd
);
	import cau_pkg::*;

	localparam logic [1:0] ST_ACCEPT = 2'd0;
	localparam logic [1:0] ST_LOAD   = 2'd1;
	localparam logic [1:0] ST_DIVIDE = 2'd2;
	localparam logic [1:0] ST_FINISH = 2'd3;

	logic [1:0]           state_q;
	logic [STEP_BITS-1:0] step_q;
	logic                 out_valid_q;
	logic                 slot_free;

	assign s_tready  = (state_q == ST_ACCEPT);
	assign m_tvalid  = out_valid_q;
	assign slot_free = !out_valid_q || m_tready;

	always_comb begin
		cmd          = '0;
		cmd.accept   = s_tvalid && s_tready;
		cmd.div_load = (state_q == ST_LOAD);
		cmd.div_step = (state_q == ST_DIVIDE);
		cmd.out_load = (state_q == ST_FINISH) && slot_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_ACCEPT;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_ACCEPT: begin
					if (cmd.accept && status.last_item) begin
						state_q <= ST_LOAD;
					end
				end
				ST_LOAD: begin
					step_q  <= '0;
					state_q <= ST_DIVIDE;
				end
				ST_DIVIDE: begin
					if (step_q == STEP_BITS'(QUO_BITS - 1)) begin
						state_q <= ST_FINISH;
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				ST_FINISH: begin
					if (slot_free) begin
						state_q <= ST_ACCEPT;
					end
				end
				default: begin
					state_q <= ST_ACCEPT;
				end
			endcase
		end
	end

endmodule

// ===== rtl/cau_datapath.sv =====
// cau_datapath: class count register, running max/argmax/sum, shift-subtract
// divider and output register. Depends on cau_pkg.
`timescale 1ns / 1ps
module cau_datapath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [cau_pkg::CFG_BITS-1:0]  cfg_data,
	input  logic [cau_pkg::COUNT_BITS-1:0] class_count,
	input  cau_pkg::cau_cmd_t             cmd,
	output cau_pkg::cau_status_t          status,
	output logic [cau_pkg::CLASS_BITS-1:0] most_likely_class,
	output logic [cau_pkg::QUO_BITS-1:0]  uncertainty_percent,
	output logic                          sum_zero_error
);
	import cau_pkg::*;

	logic [CFG_BITS-1:0]   num_classes_q;
	logic [CFG_BITS-1:0]   n_eff;
	logic [CLASS_BITS-1:0] pos_q;
	logic [COUNT_BITS-1:0] best_q;
	logic [CLASS_BITS-1:0] best_class_q;
	logic [SUM_BITS-1:0]   sum_q;
	logic [DIV_BITS-1:0]   rem_q;
	logic [DIV_BITS-1:0]   den_q;
	logic [QUO_BITS-1:0]   quo_q;
	logic                  ge;
	logic                  last_item;

	always_comb begin
		n_eff = num_classes_q;
		if (num_classes_q == '0) begin
			n_eff = CFG_BITS'(1);
		end else if (num_classes_q > CFG_BITS'(MAX_CLASSES)) begin
			n_eff = CFG_BITS'(MAX_CLASSES);
		end
	end

	assign last_item        = ({1'b0, pos_q} + CFG_BITS'(1)) >= n_eff;
	assign status.last_item = last_item;
	assign ge               = rem_q >= den_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_classes_q <= CFG_BITS'(1);
			pos_q         <= '0;
			best_q        <= '0;
			best_class_q  <= '0;
			sum_q         <= '0;
		end else begin
			if (cfg_we) begin
				num_classes_q <= cfg_data;
			end
			if (cmd.accept) begin
				if (pos_q == '0) begin
					best_q       <= class_count;
					best_class_q <= '0;
					sum_q        <= SUM_BITS'(class_count);
				end else begin
					if (class_count > best_q) begin
						best_q       <= class_count;
						best_class_q <= pos_q;
					end
					sum_q <= sum_q + SUM_BITS'(class_count);
				end
				pos_q <= last_item ? '0 : pos_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_load) begin
			rem_q <= DIV_BITS'(best_q) * DIV_BITS'(PERCENT);
			den_q <= DIV_BITS'(sum_q) << (QUO_BITS - 1);
		end else if (cmd.div_step) begin
			if (ge) begin
				rem_q <= rem_q - den_q;
			end
			den_q <= den_q >> 1;
			quo_q <= {quo_q[QUO_BITS-2:0], ge};
		end
		if (cmd.out_load) begin
			most_likely_class <= best_class_q;
			if (sum_q == '0) begin
				uncertainty_percent <= '0;
				sum_zero_error      <= 1'b1;
			end else begin
				uncertainty_percent <= QUO_BITS'(PERCENT) - quo_q;
				sum_zero_error      <= 1'b0;
			end
		end
	end

endmodule

// ===== rtl/class_argmax_uncertainty.sv =====
// class_argmax_uncertainty: top level; joins cau_ctrl and cau_datapath.
// Depends on cau_pkg, cau_ctrl, cau_datapath.
`timescale 1ns / 1ps
// Takes one class vote count per word, classes 0 to num_classes-1 of a pixel
// in order, and after the last class of the pixel returns the first class
// with the highest count and 100 - floor(100*max/sum), or an error flag with
// uncertainty 0 when all counts were zero. Counts of a pixel may come back to
// back; after the last count of a pixel the input stalls to load the divider,
// run 7 shift-subtract steps and write the output register, and stalls longer
// while a previous result still waits in the output register. The divider
// yields one quotient bit per cycle. num_classes of 0 acts as 1; values above
// 256 act as 256. Write num_classes only while the block is idle.
module class_argmax_uncertainty (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [cau_pkg::CFG_BITS-1:0]      cfg_data,      // num_classes
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [cau_pkg::IN_DATA_BITS-1:0]  s_tdata,       // class_count
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// most_likely_class, uncertainty_percent, zero pad
	output logic [cau_pkg::OUT_DATA_BITS-1:0] m_tdata,
	output logic                              m_tuser        // sum_zero_error
);
	import cau_pkg::*;

	cau_cmd_t              cmd;
	cau_status_t           status;
	logic [CLASS_BITS-1:0] most_likely_class;
	logic [QUO_BITS-1:0]   uncertainty_percent;

	assign cfg_ready = 1'b1;
	assign m_tdata   = OUT_DATA_BITS'({uncertainty_percent, most_likely_class});

	cau_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.status   (status),
		.cmd      (cmd)
	);

	cau_datapath u_datapath (
		.clk                 (clk),
		.arst_n              (arst_n),
		.cfg_we              (cfg_valid && cfg_ready),
		.cfg_data            (cfg_data),
		.class_count         (s_tdata[COUNT_BITS-1:0]),
		.cmd                 (cmd),
		.status              (status),
		.most_likely_class   (most_likely_class),
		.uncertainty_percent (uncertainty_percent),
		.sum_zero_error      (m_tuser)
	);

endmodule

// ===== tb/class_argmax_uncertainty_tb.sv =====
// class_argmax_uncertainty_tb: self-checking testbench for the class argmax and uncertainty block.
// Feeds per-class vote counts and checks each pixel result against a cycle-free predictor.
// Depends on cau_pkg and class_argmax_uncertainty.
`timescale 1ns / 1ps
module class_argmax_uncertainty_tb;
	import cau_pkg::*;

	localparam int CYCLE_LIMIT   = 1_000_000;
	localparam int RANDOM_COUNTS = 2000;
	localparam int LONG_HOLD     = 300;
	localparam int SETTLE_CYCLES = 16;

	typedef enum int {PIX_RANDOM, PIX_TINY, PIX_ZERO, PIX_FLAT, PIX_PEAK} pixel_style_t;

	typedef struct packed {
		logic [CLASS_BITS-1:0] best_class;
		logic [QUO_BITS-1:0]   uncertainty;
		logic                  zero_sum;
	} pixel_result_t;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     cfg_valid = 1'b0;
	logic                     cfg_ready;
	logic [CFG_BITS-1:0]      cfg_data = '0;
	logic                     s_tvalid = 1'b0;
	logic                     s_tready;
	logic [IN_DATA_BITS-1:0]  s_tdata = '0;
	logic                     m_tvalid;
	logic                     m_tready = 1'b0;
	logic [OUT_DATA_BITS-1:0] m_tdata;
	logic                     m_tuser;

	class_argmax_uncertainty uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	logic [COUNT_BITS-1:0] pending_counts[$];
	pixel_result_t         expected_pixels[$];

	// predictor state
	logic [CFG_BITS-1:0]   classes_setting = 9'd1;
	logic [CLASS_BITS-1:0] class_pos = '0;
	logic [COUNT_BITS-1:0] best_count = '0;
	logic [CLASS_BITS-1:0] best_class = '0;
	logic [SUM_BITS-1:0]   count_sum = '0;

	int counts_queued = 0;
	int counts_sent = 0;
	int pixels_checked = 0;
	int zero_sum_pixels = 0;
	int mismatches = 0;
	int settings_used = 0;
	int cycle_count = 0;
	int tx_idle_pct = 0;
	int rx_idle_pct = 0;
	int tx_gap = 0;
	int rx_stall = 0;
	int hold_request = 0;
	logic rx_hold = 1'b0;

	function automatic int pick_gap();
		if ($urandom_range(0, 99) < 88)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic int effective_classes(input logic [CFG_BITS-1:0] setting);
		if (setting == 0)
			return 1;
		if (setting > MAX_CLASSES)
			return MAX_CLASSES;
		return int'(setting);
	endfunction

	task automatic accumulate_count(input logic [COUNT_BITS-1:0] count);
		pixel_result_t r;
		int unsigned   pct;
		if (class_pos == 0) begin
			best_count = count;
			best_class = '0;
			count_sum  = SUM_BITS'(count);
		end else begin
			if (count > best_count) begin
				best_count = count;
				best_class = class_pos;
			end
			count_sum = count_sum + SUM_BITS'(count);
		end
		if (int'(class_pos) + 1 >= effective_classes(classes_setting)) begin
			r.best_class = best_class;
			if (count_sum != 0) begin
				pct           = (PERCENT * int'(best_count)) / int'(count_sum);
				r.uncertainty = QUO_BITS'(PERCENT - pct);
				r.zero_sum    = 1'b0;
			end else begin
				r.uncertainty = '0;
				r.zero_sum    = 1'b1;
			end
			expected_pixels.push_back(r);
			class_pos = '0;
		end else begin
			class_pos = class_pos + 1'b1;
		end
	endtask

	// sender: one word per handshake, random gaps between words
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				accumulate_count(s_tdata[COUNT_BITS-1:0]);
				counts_sent++;
			end
			if (!s_tvalid || s_tready) begin
				if (tx_gap > 0) begin
					tx_gap--;
					s_tvalid <= 1'b0;
				end else if (pending_counts.size() > 0) begin
					s_tvalid <= 1'b1;
					s_tdata  <= IN_DATA_BITS'(pending_counts.pop_front());
					tx_gap = ($urandom_range(0, 99) < tx_idle_pct) ? pick_gap() : 0;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// receiver: check each result word, random stalls plus requested hold-off
	always @(posedge clk) begin
		pixel_result_t exp_r;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (expected_pixels.size() == 0) begin
					$error("result word with no pixel pending: class %0d",
						m_tdata[CLASS_BITS-1:0]);
					mismatches++;
				end else begin
					exp_r = expected_pixels.pop_front();
					pixels_checked++;
					if (exp_r.zero_sum)
						zero_sum_pixels++;
					if (m_tdata[CLASS_BITS-1:0] !== exp_r.best_class) begin
						$error("most_likely_class: expected %0d, got %0d",
							exp_r.best_class, m_tdata[CLASS_BITS-1:0]);
						mismatches++;
					end
					if (m_tdata[CLASS_BITS +: QUO_BITS] !== exp_r.uncertainty) begin
						$error("uncertainty_percent: expected %0d, got %0d",
							exp_r.uncertainty, m_tdata[CLASS_BITS +: QUO_BITS]);
						mismatches++;
					end
					if (m_tuser !== exp_r.zero_sum) begin
						$error("sum_zero_error: expected %0d, got %0d",
							exp_r.zero_sum, m_tuser);
						mismatches++;
					end
				end
			end
			if (rx_stall > 0) begin
				rx_stall--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= !rx_hold;
				if ($urandom_range(0, 99) < rx_idle_pct)
					rx_stall = pick_gap();
			end
		end
	end

	initial begin
		for (int k = 1; k <= 2; k++) begin
			wait (hold_request == k);
			@(posedge clk);
			rx_hold <= 1'b1;
			repeat (LONG_HOLD) @(posedge clk);
			rx_hold <= 1'b0;
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	task automatic write_classes(input logic [CFG_BITS-1:0] setting);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= setting;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		classes_setting = setting;
		settings_used++;
		@(negedge clk);
	endtask

	task automatic send_count(input logic [COUNT_BITS-1:0] count);
		pending_counts.push_back(count);
		counts_queued++;
	endtask

	task automatic wait_idle();
		@(negedge clk);
		while (pending_counts.size() != 0 || s_tvalid || expected_pixels.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic queue_pixel(input int n);
		pixel_style_t          style;
		logic [COUNT_BITS-1:0] flat;
		logic [COUNT_BITS-1:0] c;
		int                    peak;
		style = pixel_style_t'($urandom_range(0, 4));
		flat  = COUNT_BITS'($urandom);
		peak  = $urandom_range(0, n - 1);
		for (int i = 0; i < n; i++) begin
			case (style)
				PIX_RANDOM: c = COUNT_BITS'($urandom);
				PIX_TINY:   c = COUNT_BITS'($urandom_range(0, 3));
				PIX_ZERO:   c = '0;
				PIX_FLAT:   c = flat;
				default:    c = (i == peak) ? '1 : COUNT_BITS'($urandom_range(0, 1000));
			endcase
			send_count(c);
		end
	endtask

	initial begin
		logic [CFG_BITS-1:0] setting;
		int                  eff;
		int                  pixels;
		int                  phase;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset setting of one class per pixel
		send_count(16'd0);
		send_count(16'hFFFF);
		send_count(16'd1);
		wait_idle();

		// zero acts as one class
		write_classes(9'd0);
		send_count(16'd7);
		send_count(16'd0);
		wait_idle();

		// ties, all-zero pixel, late maximum, largest counts
		write_classes(9'd3);
		for (int i = 0; i < 3; i++)
			send_count(16'd5);
		for (int i = 0; i < 3; i++)
			send_count(16'd0);
		send_count(16'd0);
		send_count(16'hFFFF);
		send_count(16'hFFFF);
		send_count(16'd1);
		send_count(16'd2);
		send_count(16'hFFFF);
		wait_idle();

		write_classes(9'd2);
		send_count(16'hFFFF);
		send_count(16'hFFFF);
		wait_idle();

		// change the setting in the middle of a pixel
		write_classes(9'd4);
		send_count(16'd10);
		send_count(16'd20);
		wait_idle();
		write_classes(9'd3);
		send_count(16'd30);
		wait_idle();
		write_classes(9'd5);
		send_count(16'd1);
		send_count(16'd2);
		send_count(16'd3);
		wait_idle();
		write_classes(9'd1);
		send_count(16'd4);
		wait_idle();

		phase = 0;
		while (counts_queued < RANDOM_COUNTS + 26) begin
			case (phase)
				0: setting = 9'd511;
				1: setting = 9'd256;
				2: setting = 9'd1;
				3: setting = 9'd2;
				default: begin
					case ($urandom_range(0, 19))
						0:       setting = 9'd0;
						1:       setting = CFG_BITS'($urandom_range(257, 511));
						2:       setting = 9'd256;
						3, 4:    setting = CFG_BITS'($urandom_range(9, 64));
						default: setting = CFG_BITS'($urandom_range(1, 8));
					endcase
				end
			endcase
			write_classes(setting);
			eff = effective_classes(setting);
			case ($urandom_range(0, 2))
				0:       tx_idle_pct = 0;
				1:       tx_idle_pct = 10;
				default: tx_idle_pct = 40;
			endcase
			case ($urandom_range(0, 2))
				0:       rx_idle_pct = 0;
				1:       rx_idle_pct = 10;
				default: rx_idle_pct = 40;
			endcase
			if (phase == 2 || phase == 3)
				pixels = 150;
			else if (eff > 32)
				pixels = 1;
			else
				pixels = $urandom_range(3, 160 / eff);
			for (int p = 0; p < pixels; p++)
				queue_pixel(eff);
			// leave a pixel open for the next setting now and then
			if (eff > 1 && $urandom_range(0, 3) == 0)
				for (int i = $urandom_range(1, eff - 1); i > 0; i--)
					send_count(COUNT_BITS'($urandom));
			if (phase == 2 || phase == 3)
				hold_request = phase - 1;
			wait_idle();
			phase++;
		end

		repeat (SETTLE_CYCLES) @(negedge clk);
		if (expected_pixels.size() != 0) begin
			$error("%0d pixel results never arrived", expected_pixels.size());
			mismatches++;
		end
		$display("Sent %0d class counts under %0d class-count settings",
			counts_sent, settings_used);
		$display("(0, 1, 256, 511 among them), checked %0d pixel results,",
			pixels_checked);
		$display("%0d of them zero-sum, with stalls on both sides.", zero_sum_pixels);
		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
